// ===== rtl/csc_pkg.sv =====
// Shared constants and types for the constrained stem counter.
package csc_pkg;

    localparam int MAX_LEN_DEF = 24;
    localparam int FIELD_W     = 5;
    localparam int CNT_W       = 64;
    localparam int OUT_W       = 63;
    localparam int CFG_IDX_W   = 2;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    localparam logic [CFG_IDX_W-1:0] REG_AU_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GC_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GU_LIMIT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSING_PAIRS = 2'd3;

    localparam field_t AU_LIMIT_RST      = 5'd24;
    localparam field_t GC_LIMIT_RST      = 5'd24;
    localparam field_t GU_LIMIT_RST      = 5'd0;
    localparam field_t CLOSING_PAIRS_RST = 5'd1;

endpackage

// ===== rtl/csc_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module csc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 625
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
    output logic [WIDTH-1:0]           rd_data_a,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
    output logic [WIDTH-1:0]           rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/constrained_stem_count_dp.sv =====
// Constrained stem counter: sweeps an (AU, GC) count table once per stem position, then once more to sum it.
// An invalid beat skips the sweeps and goes straight to its result.
// Throughput: one beat at a time; one table cell per cycle through two ping-pong table RAMs.
// Reset (aresetn, synchronous, active low) clears control and restores register defaults;
// the table RAMs are not cleared, since the first sweep takes its start values from logic.
module constrained_stem_count_dp
    import csc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_stem_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_sequence_count,
    output logic                 m_invalid,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_wdata
);

    localparam int SIDE  = MAX_LEN + 1;
    localparam int CELLS = SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0]      SIDE_A = AW'(SIDE);
    localparam logic [FIELD_W-1:0] MAX_F  = FIELD_W'(MAX_LEN);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;

    field_t au_limit_reg, gc_limit_reg, gu_limit_reg, closing_reg;

    logic [2:0]    state_reg, state_next;
    field_t        len_reg, len_next;
    field_t        au_reg, au_next;
    field_t        gcr_reg, gcr_next;
    field_t        gu_reg, gu_next;
    field_t        rest_reg, rest_next;
    field_t        i_reg, i_next;
    logic          inv_reg, inv_next;
    logic          virt_reg, virt_next;
    logic          src_reg, src_next;
    logic          sum_mode_reg, sum_mode_next;
    field_t        a_reg, a_next;
    field_t        b_reg, b_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] row_reg, row_next;
    logic          issue;

    logic          v1_reg;
    field_t        a1_reg, b1_reg;
    logic [AW-1:0] addr1_reg;
    cnt_t          lp_reg;
    cnt_t          acc_reg, acc_next;

    logic          m_valid_reg;
    logic [OUT_W-1:0] m_count_reg;
    logic          m_invalid_reg;
    logic          out_load;

    field_t        len_c, au_c, gc_c, gu_c;

    logic [AW-1:0] rd_addr_b;
    cnt_t          m0_a, m0_b, m1_a, m1_b;
    cnt_t          rd_a, rd_b, pa, pu, pl, cell_val;
    logic [FIELD_W:0] s_ab, diff;
    logic          cond;
    logic          we0, we1;
    cnt_t          shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            au_limit_reg <= AU_LIMIT_RST;
            gc_limit_reg <= GC_LIMIT_RST;
            gu_limit_reg <= GU_LIMIT_RST;
            closing_reg  <= CLOSING_PAIRS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_AU_LIMIT:      au_limit_reg <= cfg_wdata;
                REG_GC_LIMIT:      gc_limit_reg <= cfg_wdata;
                REG_GU_LIMIT:      gu_limit_reg <= cfg_wdata;
                REG_CLOSING_PAIRS: closing_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        len_c = (s_stem_length > MAX_F) ? MAX_F : s_stem_length;
        au_c  = (au_limit_reg < len_c) ? au_limit_reg : len_c;
        gc_c  = (gc_limit_reg < len_c) ? gc_limit_reg : len_c;
        gu_c  = (gu_limit_reg < len_c) ? gu_limit_reg : len_c;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign issue   = (state_reg == ST_SWEEP);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        au_next       = au_reg;
        gcr_next      = gcr_reg;
        gu_next       = gu_reg;
        rest_next     = rest_reg;
        i_next        = i_reg;
        inv_next      = inv_reg;
        virt_next     = virt_reg;
        src_next      = src_reg;
        sum_mode_next = sum_mode_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        addr_next     = addr_reg;
        row_next      = row_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    len_next      = len_c;
                    au_next       = au_c;
                    gcr_next      = gc_c - closing_reg;
                    gu_next       = gu_c;
                    rest_next     = len_c - closing_reg;
                    inv_next      = (closing_reg > gc_c);
                    virt_next     = 1'b1;
                    sum_mode_next = (len_c == closing_reg);
                    i_next        = (len_c == closing_reg) ? '0 : field_t'(1);
                    a_next        = '0;
                    b_next        = '0;
                    addr_next     = '0;
                    row_next      = '0;
                    state_next    = (closing_reg > gc_c) ? ST_DONE : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (a_reg == au_reg && b_reg == gcr_reg) begin
                    state_next = ST_DRAIN;
                end else if (b_reg == gcr_reg) begin
                    a_next    = a_reg + field_t'(1);
                    b_next    = '0;
                    row_next  = row_reg + SIDE_A;
                    addr_next = row_reg + SIDE_A;
                end else begin
                    b_next    = b_reg + field_t'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (sum_mode_reg) begin
                    state_next = ST_DONE;
                end else begin
                    virt_next = 1'b0;
                    src_next  = ~src_reg;
                    if (i_reg == rest_reg) begin
                        sum_mode_next = 1'b1;
                    end else begin
                        i_next = i_reg + field_t'(1);
                    end
                    a_next     = '0;
                    b_next     = '0;
                    addr_next  = '0;
                    row_next   = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign rd_addr_b = (a_reg == '0) ? addr_reg : addr_reg - SIDE_A;

    csc_ram #(
        .WIDTH(CNT_W),
        .DEPTH(CELLS)
    ) u_table0 (
        .clk       (aclk),
        .wr_en     (we0),
        .wr_addr   (addr1_reg),
        .wr_data   (cell_val),
        .rd_addr_a (addr_reg),
        .rd_data_a (m0_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (m0_b)
    );

    csc_ram #(
        .WIDTH(CNT_W),
        .DEPTH(CELLS)
    ) u_table1 (
        .clk       (aclk),
        .wr_en     (we1),
        .wr_addr   (addr1_reg),
        .wr_data   (cell_val),
        .rd_addr_a (addr_reg),
        .rd_data_a (m1_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (m1_b)
    );

    // The table selected by src_reg holds the previous position; the other one is written.
    always_comb begin
        rd_a = src_reg ? m1_a : m0_a;
        rd_b = src_reg ? m1_b : m0_b;
        if (virt_reg) begin
            pa = cnt_t'(a1_reg == '0 && b1_reg == '0);
        end else begin
            pa = rd_a;
        end
        if (a1_reg == '0) begin
            pu = '0;
        end else if (virt_reg) begin
            pu = cnt_t'(a1_reg == field_t'(1) && b1_reg == '0);
        end else begin
            pu = rd_b;
        end
        pl       = (b1_reg == '0) ? '0 : lp_reg;
        s_ab     = {1'b0, a1_reg} + {1'b0, b1_reg};
        diff     = {1'b0, i_reg} - s_ab;
        cond     = (s_ab <= {1'b0, i_reg}) && (diff <= {1'b0, gu_reg});
        cell_val = cond ? (pa + pu + pl) : '0;
        we0      = v1_reg && !sum_mode_reg && src_reg;
        we1      = v1_reg && !sum_mode_reg && !src_reg;
        acc_next = acc_reg;
        if (state_reg == ST_IDLE) begin
            acc_next = '0;
        end else if (v1_reg && sum_mode_reg && cond) begin
            acc_next = acc_reg + pa;
        end
    end

    assign shifted = acc_reg << len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            virt_reg     <= 1'b0;
            src_reg      <= 1'b0;
            sum_mode_reg <= 1'b0;
            v1_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            virt_reg     <= virt_next;
            src_reg      <= src_next;
            sum_mode_reg <= sum_mode_next;
            v1_reg       <= issue;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        au_reg    <= au_next;
        gcr_reg   <= gcr_next;
        gu_reg    <= gu_next;
        rest_reg  <= rest_next;
        i_reg     <= i_next;
        inv_reg   <= inv_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        addr_reg  <= addr_next;
        row_reg   <= row_next;
        a1_reg    <= a_reg;
        b1_reg    <= b_reg;
        addr1_reg <= addr_reg;
        acc_reg   <= acc_next;
        if (v1_reg) begin
            lp_reg <= pa;
        end
        if (out_load) begin
            m_count_reg   <= inv_reg ? '0 : shifted[OUT_W-1:0];
            m_invalid_reg <= inv_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sequence_count = m_count_reg;
    assign m_invalid        = m_invalid_reg;

endmodule

// ===== tb/sv/stem_count_checker.sv =====
// Watches the stem counter's channels, predicts each count and compares it with the block's output.
module stem_count_checker
    import csc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_stem_length,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [OUT_W-1:0]     m_sequence_count,
    input  logic                 m_invalid,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_wdata,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int SIDE_MAX = MAX_LEN_DEF;

    typedef struct packed {
        logic [OUT_W-1:0] count;
        logic             invalid;
    } stem_result_t;

    int au_lim = int'(AU_LIMIT_RST);
    int gc_lim = int'(GC_LIMIT_RST);
    int gu_lim = int'(GU_LIMIT_RST);
    int closing = int'(CLOSING_PAIRS_RST);

    stem_result_t expected_counts[$];

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic stem_result_t count_stems(input field_t stem_in);
        cnt_t prev [0:SIDE_MAX][0:SIDE_MAX];
        cnt_t cur [0:SIDE_MAX][0:SIDE_MAX];
        cnt_t total;
        cnt_t cell_sum;
        cnt_t shifted;
        int len, au, gc, gu, gcr, rest;
        stem_result_t res;
        len = (int'(stem_in) > SIDE_MAX) ? SIDE_MAX : int'(stem_in);
        au = (au_lim < len) ? au_lim : len;
        gc = (gc_lim < len) ? gc_lim : len;
        gu = (gu_lim < len) ? gu_lim : len;
        res.count = '0;
        res.invalid = 1'b0;
        if (closing > gc) begin
            res.invalid = 1'b1;
            return res;
        end
        gcr = gc - closing;
        rest = len - closing;
        foreach (prev[a, b]) begin
            prev[a][b] = '0;
            cur[a][b] = '0;
        end
        prev[0][0] = 64'd1;
        for (int i = 1; i <= rest; i++) begin
            for (int a = 0; a <= au; a++) begin
                for (int b = 0; b <= gcr; b++) begin
                    cell_sum = '0;
                    if (a + b <= i && i - a - b <= gu) begin
                        cell_sum = prev[a][b];
                        if (a > 0) cell_sum += prev[a-1][b];
                        if (b > 0) cell_sum += prev[a][b-1];
                    end
                    cur[a][b] = cell_sum;
                end
            end
            prev = cur;
        end
        total = '0;
        for (int a = 0; a <= au; a++)
            for (int b = 0; b <= gcr; b++)
                if (a + b <= rest && rest - a - b <= gu)
                    total += prev[a][b];
        shifted = total << len;
        res.count = shifted[OUT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        stem_result_t want;
        if (!aresetn) begin
            au_lim = int'(AU_LIMIT_RST);
            gc_lim = int'(GC_LIMIT_RST);
            gu_lim = int'(GU_LIMIT_RST);
            closing = int'(CLOSING_PAIRS_RST);
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_AU_LIMIT:      au_lim = int'(cfg_wdata);
                    REG_GC_LIMIT:      gc_lim = int'(cfg_wdata);
                    REG_GU_LIMIT:      gu_lim = int'(cfg_wdata);
                    REG_CLOSING_PAIRS: closing = int'(cfg_wdata);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_counts = {expected_counts, count_stems(s_stem_length)};
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    $error("Result beat arrived with no count expected.");
                    mismatches++;
                end else begin
                    want = expected_counts.pop_front();
                    if (m_sequence_count !== want.count) begin
                        $error("sequence_count: expected %0d, got %0d",
                               want.count, m_sequence_count);
                        mismatches++;
                    end
                    if (m_invalid !== want.invalid) begin
                        $error("invalid: expected %0d, got %0d", want.invalid, m_invalid);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_counts.size();
    end

endmodule

// ===== tb/sv/constrained_stem_count_dp_test.sv =====
// Top of the stem counter testbench: clock, reset, stimulus, receiver stalls and the verdict.
module constrained_stem_count_dp_test;
    import csc_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [FIELD_W-1:0]   s_stem_length;
    logic                 m_valid;
    logic                 m_ready;
    logic [OUT_W-1:0]     m_sequence_count;
    logic                 m_invalid;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_wdata;

    int mismatches;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    always #5 aclk = ~aclk;

    constrained_stem_count_dp dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stem_length    (s_stem_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sequence_count (m_sequence_count),
        .m_invalid        (m_invalid),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    stem_count_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stem_length    (s_stem_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sequence_count (m_sequence_count),
        .m_invalid        (m_invalid),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    function automatic field_t pick_limit();
        return ($urandom_range(9) == 0) ? field_t'($urandom_range(31))
                                        : field_t'($urandom_range(24));
    endfunction

    task automatic set_limits(input field_t au, input field_t gc, input field_t gu,
                              input field_t cp);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_AU_LIMIT;
        cfg_wdata <= au;
        @(negedge aclk);
        cfg_index <= REG_GC_LIMIT;
        cfg_wdata <= gc;
        @(negedge aclk);
        cfg_index <= REG_GU_LIMIT;
        cfg_wdata <= gu;
        @(negedge aclk);
        cfg_index <= REG_CLOSING_PAIRS;
        cfg_wdata <= cp;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic play(input field_t lens[$]);
        foreach (lens[k]) begin
            while ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_stem_length <= lens[k];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic play_random(input int n, input int idle, input int stall,
                               input bit hold_off);
        field_t lens[$];
        set_limits(pick_limit(), pick_limit(), pick_limit(),
                   ($urandom_range(4) == 0) ? field_t'($urandom_range(31))
                                            : field_t'($urandom_range(3)));
        idle_pct = idle;
        stall_pct = stall;
        repeat (n) begin
            if (hold_off)
                lens = {lens, field_t'($urandom_range(6))};
            else if ($urandom_range(99) < 85)
                lens = {lens, field_t'($urandom_range(10))};
            else
                lens = {lens, field_t'($urandom_range(31))};
        end
        if (hold_off) hold_cycles = 3000;
        play(lens);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        field_t stems[$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_stem_length = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_AU_LIMIT;
        cfg_wdata = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset limits first, then limits written at their defaults, then fixed limit sets, some out of range.
        stems = '{5'd0, 5'd1, 5'd2};
        play(stems);
        idle_pct = 7;
        stall_pct = 7;
        set_limits(AU_LIMIT_RST, GC_LIMIT_RST, GU_LIMIT_RST, CLOSING_PAIRS_RST);
        stems = '{5'd24, 5'd31, 5'd13};
        play(stems);
        set_limits(5'd0, 5'd0, 5'd24, 5'd0);
        stems = '{5'd0, 5'd24, 5'd7};
        play(stems);
        set_limits(5'd24, 5'd24, 5'd24, 5'd0);
        stems = '{5'd24, 5'd31, 5'd3};
        play(stems);
        set_limits(5'd31, 5'd31, 5'd31, 5'd31);
        stems = '{5'd31, 5'd24, 5'd0};
        play(stems);
        set_limits(5'd2, 5'd5, 5'd1, 5'd3);
        stems = '{5'd3, 5'd2, 5'd8, 5'd10, 5'd16};
        play(stems);

        play_random(20, 0, 0, 1'b0);
        play_random(20, 51, 0, 1'b0);
        play_random(20, 0, 51, 1'b0);
        play_random(20, 7, 7, 1'b0);
        play_random(20, 0, 0, 1'b1);

        repeat (50) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
